### rtl/rms_ot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_ot_pkg : constants for the RMS meter with offset tracking
// Fixed-point formats, window counter widths and iteration counts.
// ----------------------------------------------------------------------------
package rms_ot_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int OFFSET_SHIFT = 10;
    localparam int FRAC_BITS    = 16;
    localparam int DIFF_FRAC    = 8;

    // offset: SAMPLE_BITS.FRAC_BITS unsigned
    localparam int OFF_W  = SAMPLE_BITS + FRAC_BITS;
    // signed difference sample - offset
    localparam int D_W    = OFF_W + 1;
    // difference truncated to DIFF_FRAC fractional bits, and its magnitude
    localparam int D8_W   = D_W - (FRAC_BITS - DIFF_FRAC);
    localparam int MAG_W  = D8_W;
    localparam int SQ_W   = 2 * MAG_W;

    localparam int SUM_W  = 56;
    localparam int CNT_W  = 16;
    localparam int N_W    = CNT_W + 1;
    localparam int RMS_W  = 10;

    localparam logic [OFF_W-1:0] OFFSET_START = OFF_W'(512) << FRAC_BITS;
    localparam logic [CNT_W-1:0] COUNT_RESET  = CNT_W'(1000);
    localparam logic [RMS_W-1:0] RMS_MAX      = {RMS_W{1'b1}};

    // restoring divide: one quotient bit per step
    localparam int DIV_STEPS  = SUM_W;
    // digit-by-digit root: one root bit (two radicand bits) per step
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ITER_W     = $clog2(DIV_STEPS);

    // shared subtractor width
    localparam int ALU_W = (REM_W > N_W + 1) ? REM_W : N_W + 1;

endpackage

### rtl/rms_meter_with_offset_tracking_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_meter_with_offset_tracking_unit : true RMS meter with DC offset removal
// Tracks the ADC offset with a first-order IIR, squares and sums the
// offset-free samples and emits the integer RMS at the end of each window.
// ----------------------------------------------------------------------------
// Each accepted request carries one 10-bit ADC sample. The running offset
// (start 512.0, 16 fractional bits, kept across windows) moves by
// (sample - offset)/1024, the new offset is subtracted, the difference is cut
// to 8 fractional bits, squared and added to a 56-bit sum. When the number of
// samples taken reaches i_cfg_sample_count (0 acts as 1) the block emits
// floor(sqrt(sum / n)) saturated to 1023, where n is the number of samples
// actually summed, and clears the sum and the count. The input takes one
// request only while o_stall is low: a sample that does not close a window
// runs the offset update, offset removal, square and sum states before the
// next can be taken; a sample that closes a window also runs 56 divide
// steps, 28 root steps and the result load, since the divide and the square
// root each run one bit per cycle through a single shared subtractor. The
// result sits in an output register, so a new sample is taken while it
// waits; the result load waits only if the previous result has not yet
// been taken. The window length register is written through its own
// valid/ready port that is always ready; write it only while the block is
// idle. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module rms_meter_with_offset_tracking_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [rms_ot_pkg::SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [rms_ot_pkg::RMS_W-1:0]       o_rms_value,
    // window length register
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rms_ot_pkg::CNT_W-1:0]       i_cfg_sample_count
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_FILT = 8'b0000_0010,  // offset update
        ST_DIFF = 8'b0000_0100,  // offset removal, truncation, magnitude
        ST_MUL  = 8'b0000_1000,  // square
        ST_ACC  = 8'b0001_0000,  // sum and window check
        ST_DIV  = 8'b0010_0000,  // sum / n, one bit per cycle
        ST_SQRT = 8'b0100_0000,  // root, one bit per cycle
        ST_FIN  = 8'b1000_0000   // load result register
    } t_state;

    t_state                                 r_state,    n_state;
    logic [rms_ot_pkg::CNT_W-1:0]           r_cfg_cnt,  n_cfg_cnt;
    logic [rms_ot_pkg::SAMPLE_BITS-1:0]     r_smp,      n_smp;
    logic [rms_ot_pkg::OFF_W-1:0]           r_offset,   n_offset;
    logic [rms_ot_pkg::MAG_W-1:0]           r_mag,      n_mag;
    logic [rms_ot_pkg::SQ_W-1:0]            r_sq,       n_sq;
    logic [rms_ot_pkg::SUM_W-1:0]           r_sum,      n_sum;
    logic [rms_ot_pkg::CNT_W-1:0]           r_count,    n_count;
    logic [rms_ot_pkg::N_W-1:0]             r_div_n,    n_div_n;
    // dividend/quotient, then radicand, shifted left one or two bits a step
    logic [rms_ot_pkg::SUM_W-1:0]           r_work,     n_work;
    logic [rms_ot_pkg::REM_W-1:0]           r_rem,      n_rem;
    logic [rms_ot_pkg::ROOT_W-1:0]          r_root,     n_root;
    logic [rms_ot_pkg::ITER_W-1:0]          r_iter,     n_iter;
    logic                                   r_out_valid, n_out_valid;
    logic [rms_ot_pkg::RMS_W-1:0]           r_rms,      n_rms;

    // datapath terms
    logic [rms_ot_pkg::OFF_W-1:0]           scaled;
    logic signed [rms_ot_pkg::D_W-1:0]      d_filt, step, d_rem, d_shr;
    logic signed [rms_ot_pkg::D8_W-1:0]     d8;
    logic [rms_ot_pkg::N_W-1:0]             n_taken, limit;
    logic [rms_ot_pkg::SUM_W-1:0]           sum_new;

    // shared subtractor
    logic [rms_ot_pkg::ALU_W-1:0]           alu_a, alu_b;
    logic [rms_ot_pkg::ALU_W:0]             alu_diff;
    logic                                   alu_ge;
    logic [rms_ot_pkg::N_W:0]               div_sh;
    logic [rms_ot_pkg::REM_W-1:0]           sqrt_sh;

    assign scaled  = {r_smp, {rms_ot_pkg::FRAC_BITS{1'b0}}};
    assign d_filt  = $signed({1'b0, scaled}) - $signed({1'b0, r_offset});
    assign step    = d_filt >>> rms_ot_pkg::OFFSET_SHIFT;
    assign d_rem   = $signed({1'b0, scaled}) - $signed({1'b0, r_offset});
    assign d_shr   = d_rem >>> (rms_ot_pkg::FRAC_BITS - rms_ot_pkg::DIFF_FRAC);
    assign d8      = d_shr[rms_ot_pkg::D8_W-1:0];

    assign n_taken = {1'b0, r_count} + rms_ot_pkg::N_W'(1);
    assign limit   = (r_cfg_cnt == '0) ? rms_ot_pkg::N_W'(1) : {1'b0, r_cfg_cnt};
    assign sum_new = r_sum + rms_ot_pkg::SUM_W'(r_sq);

    // next partial remainders for the two iterations
    assign div_sh  = {r_rem[rms_ot_pkg::N_W-1:0], r_work[rms_ot_pkg::SUM_W-1]};
    assign sqrt_sh = {r_rem[rms_ot_pkg::REM_W-3:0],
                      r_work[rms_ot_pkg::SUM_W-1 -: 2]};

    always_comb begin
        if (r_state == ST_SQRT) begin
            alu_a = rms_ot_pkg::ALU_W'(sqrt_sh);
            alu_b = rms_ot_pkg::ALU_W'({r_root, 2'b01});
        end else begin
            alu_a = rms_ot_pkg::ALU_W'(div_sh);
            alu_b = rms_ot_pkg::ALU_W'(r_div_n);
        end
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = ~alu_diff[rms_ot_pkg::ALU_W];

    always_comb begin
        n_state     = r_state;
        n_cfg_cnt   = r_cfg_cnt;
        n_smp       = r_smp;
        n_offset    = r_offset;
        n_mag       = r_mag;
        n_sq        = r_sq;
        n_sum       = r_sum;
        n_count     = r_count;
        n_div_n     = r_div_n;
        n_work      = r_work;
        n_rem       = r_rem;
        n_root      = r_root;
        n_iter      = r_iter;
        n_out_valid = r_out_valid;
        n_rms       = r_rms;

        if (i_cfg_valid) begin
            n_cfg_cnt = i_cfg_sample_count;
        end

        // result taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_smp   = i_sample;
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                n_offset = r_offset + step[rms_ot_pkg::OFF_W-1:0];
                n_state  = ST_DIFF;
            end
            ST_DIFF: begin
                n_mag   = d8[rms_ot_pkg::D8_W-1] ? rms_ot_pkg::MAG_W'(-d8)
                                                 : rms_ot_pkg::MAG_W'(d8);
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_sq    = rms_ot_pkg::SQ_W'(r_mag) * rms_ot_pkg::SQ_W'(r_mag);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (n_taken >= limit) begin
                    n_work  = sum_new;
                    n_div_n = n_taken;
                    n_rem   = '0;
                    n_iter  = '0;
                    n_sum   = '0;
                    n_count = '0;
                    n_state = ST_DIV;
                end else begin
                    n_sum   = sum_new;
                    n_count = n_taken[rms_ot_pkg::CNT_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                n_rem  = alu_ge ? rms_ot_pkg::REM_W'(alu_diff[rms_ot_pkg::N_W:0])
                                : rms_ot_pkg::REM_W'(div_sh);
                n_work = {r_work[rms_ot_pkg::SUM_W-2:0], alu_ge};
                n_iter = r_iter + rms_ot_pkg::ITER_W'(1);
                if (r_iter == rms_ot_pkg::ITER_W'(rms_ot_pkg::DIV_STEPS - 1)) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_iter  = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                n_rem  = alu_ge ? alu_diff[rms_ot_pkg::REM_W-1:0] : sqrt_sh;
                n_root = {r_root[rms_ot_pkg::ROOT_W-2:0], alu_ge};
                n_work = {r_work[rms_ot_pkg::SUM_W-3:0], 2'b00};
                n_iter = r_iter + rms_ot_pkg::ITER_W'(1);
                if (r_iter == rms_ot_pkg::ITER_W'(rms_ot_pkg::SQRT_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for room in the output register
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    if (|r_root[rms_ot_pkg::ROOT_W-1:rms_ot_pkg::DIFF_FRAC+rms_ot_pkg::RMS_W])
                    begin
                        n_rms = rms_ot_pkg::RMS_MAX;
                    end else begin
                        n_rms = r_root[rms_ot_pkg::DIFF_FRAC +: rms_ot_pkg::RMS_W];
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_cnt   <= rms_ot_pkg::COUNT_RESET;
            r_offset    <= rms_ot_pkg::OFFSET_START;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_cnt   <= n_cfg_cnt;
            r_offset    <= n_offset;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp   <= n_smp;
        r_mag   <= n_mag;
        r_sq    <= n_sq;
        r_div_n <= n_div_n;
        r_work  <= n_work;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_iter  <= n_iter;
        r_rms   <= n_rms;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_rms_value = r_rms;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // an accepted sample starts the offset update
    a_accept_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_FILT))
        else $error("accepted sample did not start processing");

    // a new result only comes from the result load state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result valid without a finished window");

    // restoring divide keeps the partial remainder below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (rms_ot_pkg::ALU_W'(r_rem) < rms_ot_pkg::ALU_W'(r_div_n)))
        else $error("divide remainder out of range");

    // root remainder never exceeds twice the partial root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |->
            (rms_ot_pkg::ALU_W'(r_rem) <= rms_ot_pkg::ALU_W'({r_root, 1'b0})))
        else $error("root remainder out of range");
`endif

endmodule

### dv/rms_ot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_ot_checker : scoreboard for the RMS meter with offset tracking
// Follows every accepted sample request through its own copy of the offset
// filter and square sum, queues the RMS of each closed window and compares
// it with what the result channel delivers.
// ----------------------------------------------------------------------------
module rms_ot_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_smp_valid,
    input  logic                               i_smp_stall,
    input  logic [rms_ot_pkg::SAMPLE_BITS-1:0] i_sample,
    // result channel
    input  logic                               i_rms_valid,
    input  logic                               i_rms_stall,
    input  logic [rms_ot_pkg::RMS_W-1:0]       i_rms_value,
    // window length register
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [rms_ot_pkg::CNT_W-1:0]       i_cfg_sample_count,
    // status to the testbench top
    output int                                 o_fail_count,
    output int                                 o_pending
);

    logic [rms_ot_pkg::CNT_W-1:0] window_len;
    logic [rms_ot_pkg::OFF_W-1:0] offset_est;
    logic [rms_ot_pkg::SUM_W-1:0] square_acc;
    logic [rms_ot_pkg::CNT_W-1:0] taken_cnt;
    logic [rms_ot_pkg::RMS_W-1:0] rms_due[$];
    int                           fails = 0;

    // largest r with r*r <= x, one bit at a time from the top
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x) begin
                r = trial;
            end
        end
        return r;
    endfunction

    // one sample through the meter; returns 1 when it closes a window
    function automatic bit meter_sample(
        input  logic [rms_ot_pkg::SAMPLE_BITS-1:0] smp,
        output logic [rms_ot_pkg::RMS_W-1:0]       rms);
        longint          scaled;
        longint          diff;
        longint          trunc;
        longint unsigned mag;
        longint unsigned n_taken;
        longint unsigned limit_n;
        longint unsigned root;
        scaled = longint'(smp) << rms_ot_pkg::FRAC_BITS;
        // IIR step, arithmetic shift rounds toward minus infinity
        diff       = scaled - longint'(offset_est);
        offset_est = rms_ot_pkg::OFF_W'(longint'(offset_est)
                                        + (diff >>> rms_ot_pkg::OFFSET_SHIFT));
        // difference against the new offset, cut to DIFF_FRAC fraction bits
        diff       = scaled - longint'(offset_est);
        trunc      = diff >>> (rms_ot_pkg::FRAC_BITS - rms_ot_pkg::DIFF_FRAC);
        mag        = (trunc < 0) ? -trunc : trunc;
        square_acc = rms_ot_pkg::SUM_W'(square_acc + mag * mag);
        n_taken    = taken_cnt + 64'd1;
        limit_n    = (window_len == '0) ? 64'd1 : window_len;
        rms        = '0;
        if (n_taken >= limit_n) begin
            root       = floor_root(square_acc / n_taken) >> rms_ot_pkg::DIFF_FRAC;
            rms        = (root > rms_ot_pkg::RMS_MAX) ? rms_ot_pkg::RMS_MAX
                                                      : rms_ot_pkg::RMS_W'(root);
            square_acc = '0;
            taken_cnt  = '0;
            return 1'b1;
        end
        taken_cnt = rms_ot_pkg::CNT_W'(n_taken);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [rms_ot_pkg::RMS_W-1:0] predicted;
        logic [rms_ot_pkg::RMS_W-1:0] want;
        if (!i_rst_n) begin
            window_len = rms_ot_pkg::COUNT_RESET;
            offset_est = rms_ot_pkg::OFFSET_START;
            square_acc = '0;
            taken_cnt  = '0;
            rms_due.delete();
        end else begin
            if (i_rms_valid && !i_rms_stall) begin
                if (rms_due.size() == 0) begin
                    $error("unexpected result: rms_value %0d", i_rms_value);
                    fails++;
                end else begin
                    want = rms_due.pop_front();
                    if (i_rms_value !== want) begin
                        $error("rms_value mismatch: expected %0d, actual %0d",
                               want, i_rms_value);
                        fails++;
                    end
                end
            end
            if (i_smp_valid && !i_smp_stall) begin
                if (meter_sample(i_sample, predicted)) begin
                    rms_due.push_back(predicted);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                window_len = i_cfg_sample_count;
            end
        end
        o_fail_count <= fails;
        o_pending    <= rms_due.size();
    end

endmodule

### dv/tb_rms_meter_with_offset_tracking_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rms_meter_with_offset_tracking_unit : testbench for the RMS meter
// Drives ADC sample requests and window length writes, stalls the result
// side at random and leaves all checking to rms_ot_checker.
// ----------------------------------------------------------------------------
module tb_rms_meter_with_offset_tracking_unit;

    // rough stimulus size; the last stretch runs with no random idling
    localparam int ITEM_TARGET     = 550;
    localparam int QUIET_FROM      = 470;
    // long enough for two window closes to back up
    localparam int HOLD_OFF_CYCLES = 600;
    // time for a sample that closes no window to finish after acceptance
    localparam int SETTLE_CYCLES   = 12;
    // end of run: wait for stragglers, then look for spurious results
    localparam int DRAIN_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 150;

    logic                               clk        = 1'b0;
    logic                               rst_n      = 1'b0;
    logic                               smp_valid  = 1'b0;
    logic                               smp_stall;
    logic [rms_ot_pkg::SAMPLE_BITS-1:0] smp_data   = '0;
    logic                               rms_valid;
    logic                               rms_stall  = 1'b0;
    logic [rms_ot_pkg::RMS_W-1:0]       rms_value;
    logic                               cfg_valid  = 1'b0;
    logic                               cfg_ready;
    logic [rms_ot_pkg::CNT_W-1:0]       cfg_window = '0;

    int fail_count;
    int pending;
    int items_sent  = 0;
    // idling switches: quiet for the final stretch, calm for whole phases
    bit quiet       = 1'b0;
    bit calm        = 1'b0;
    // long receiver hold-off: asked by stimulus, served by the result sink
    int hold_asked  = 0;
    int hold_served = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rms_meter_with_offset_tracking_unit i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (smp_valid),
        .o_stall            (smp_stall),
        .i_sample           (smp_data),
        .o_valid            (rms_valid),
        .i_stall            (rms_stall),
        .o_rms_value        (rms_value),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_sample_count (cfg_window)
    );

    rms_ot_checker i_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_smp_valid        (smp_valid),
        .i_smp_stall        (smp_stall),
        .i_sample           (smp_data),
        .i_rms_valid        (rms_valid),
        .i_rms_stall        (rms_stall),
        .i_rms_value        (rms_value),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_sample_count (cfg_window),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Offer one sample request and hold it until accepted. Afterwards the
    // sender may drop valid for a short burst. Valid is only ever assigned
    // once per edge: either the next request raises it or the gap drops it.
    task automatic send_sample(input logic [rms_ot_pkg::SAMPLE_BITS-1:0] value);
        smp_valid <= 1'b1;
        smp_data  <= value;
        @(posedge clk);
        while (smp_stall) @(posedge clk);
        items_sent++;
        if (items_sent >= QUIET_FROM) begin
            quiet <= 1'b1;
        end
        if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            smp_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every queued RMS result, then let the last
    // non-closing sample finish inside the block.
    task automatic settle();
        smp_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Window length write, only from an idle block. Lowering the length
    // while a window is part full closes it on the next sample.
    task automatic write_window(input logic [rms_ot_pkg::CNT_W-1:0] len);
        settle();
        cfg_valid  <= 1'b1;
        cfg_window <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sample shapes: full-range noise, a DC level with some ripple, or
    // rail-to-rail swings that stress the offset filter.
    function automatic logic [rms_ot_pkg::SAMPLE_BITS-1:0] pick_sample(input int shape,
                                                                       input int dc,
                                                                       input int amp);
        int v;
        case (shape)
            0: begin
                v = $urandom_range(0, 1023);
            end
            1: begin
                v = dc + int'($urandom_range(0, 2 * amp)) - amp;
            end
            default: begin
                v = ($urandom_range(0, 1) == 1) ? 1023 - int'($urandom_range(0, 3))
                                                : int'($urandom_range(0, 3));
            end
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > 1023) begin
            v = 1023;
        end
        return rms_ot_pkg::SAMPLE_BITS'(v);
    endfunction

    // Result sink: random stall bursts, plus one long hold-off on request
    // that backs the block up until it stalls its sample input.
    initial begin : result_sink
        forever begin
            @(posedge clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                rms_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
            end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
                rms_stall <= 1'b1;
                repeat ($urandom_range(1, 6) - 1) @(posedge clk);
            end else begin
                rms_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int len;
        int count;
        int shape;
        int dc;
        int amp;
        int waited;
        bit hold_done;
        hold_done = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // rails under the reset window length: no window closes yet
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd0);
        // length lowered below the part-full count: next sample closes
        // the window over all five samples taken
        write_window(rms_ot_pkg::CNT_W'(2));
        send_sample(10'd512);
        // zero length acts as one: every sample closes a window
        write_window(rms_ot_pkg::CNT_W'(0));
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd512);
        send_sample(10'd1);
        send_sample(10'd1022);
        // longest window, partly filled, then cut down to one
        write_window({rms_ot_pkg::CNT_W{1'b1}});
        for (int i = 0; i < 8; i++) begin
            send_sample((i % 2 == 0) ? 10'd0 : 10'd1023);
        end
        write_window(rms_ot_pkg::CNT_W'(1));
        send_sample(10'd1023);
        // one ordinary short window at full scale
        write_window(rms_ot_pkg::CNT_W'(3));
        repeat (3) send_sample(10'd1023);

        // --- random phases ---
        while (items_sent < ITEM_TARGET) begin
            shape = $urandom_range(0, 2);
            dc    = $urandom_range(0, 1023);
            amp   = $urandom_range(0, 511);
            calm  <= ($urandom_range(0, 3) == 0);
            if (!hold_done && items_sent >= 200) begin
                // one-sample windows while the receiver holds off: results
                // pile up and the sample input must stall
                hold_done = 1'b1;
                write_window(rms_ot_pkg::CNT_W'(1));
                hold_asked <= hold_asked + 1;
                repeat (12) send_sample(pick_sample(shape, dc, amp));
            end else begin
                case ($urandom_range(0, 19))
                    0:       len = 0;
                    1, 2:    len = $urandom_range(17, 48);
                    default: len = $urandom_range(1, 16);
                endcase
                write_window(rms_ot_pkg::CNT_W'(len));
                count = ((len == 0) ? 1 : len) * $urandom_range(1, 3);
                // sometimes stop mid-window so the next write cuts it short
                if ($urandom_range(0, 3) == 0) begin
                    count += $urandom_range(0, (len == 0) ? 1 : len);
                end
                // keep the total near the target
                if (count > ITEM_TARGET - items_sent) begin
                    count = ITEM_TARGET - items_sent;
                end
                repeat (count) send_sample(pick_sample(shape, dc, amp));
            end
        end

        // --- drain and verdict ---
        smp_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending != 0) begin
            $error("%0d rms results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hard stop: several times the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
